/* src/apm_pkg.sv */
package apm_pkg;

  localparam int unsigned DataBits   = 32;
  localparam int unsigned RpmBits    = 30;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CfgDebounce    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgStopTimeout = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgSpeedScale  = 2'd2;

  localparam logic OpPulse = 1'b0;
  localparam logic OpPoll  = 1'b1;

  localparam logic [DataBits-1:0] DebounceReset = 32'd40000;
  localparam logic [DataBits-1:0] StopReset     = 32'd3000000;
  localparam logic [DataBits-1:0] ScaleReset    = 32'd558584000;

  localparam logic [DataBits-1:0] RpmQ4Num = 32'd960000000;

  localparam int unsigned     MphNumBits = 18;
  localparam int unsigned     MphDenBits = 17;
  localparam logic [MphNumBits-1:0] MphNum = 18'd223694;
  localparam logic [MphDenBits-1:0] MphDen = 17'd100000;
  localparam int unsigned     ProdBits     = DataBits + MphNumBits;
  localparam int unsigned     MphDigitBits = 4;
  localparam int unsigned     MphSteps     = (ProdBits + MphDigitBits - 1) / MphDigitBits;
  localparam int unsigned     MphQuotBits  = MphSteps * MphDigitBits;

  localparam int unsigned DivSteps = DataBits;
  localparam int unsigned CntBits  = $clog2(DivSteps);

  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned QueuePtrBits   = $clog2(QueueDepth);
  localparam int unsigned QueueCountBits = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic                operation;
    logic [DataBits-1:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic                pulse_accepted;
    logic [DataBits-1:0] revolutions;
    logic [DataBits-1:0] period_us;
    logic [RpmBits-1:0]  rpm_q4;
    logic [DataBits-1:0] speed_mm_per_s;
    logic [DataBits-1:0] speed_milli_mph;
  } out_word_t;

  typedef struct packed {
    logic                pulse_accepted;
    logic [DataBits-1:0] revolutions;
    logic [DataBits-1:0] period_us;
  } job_t;

endpackage

/* src/anemometer_period_speed_meter_top.sv */
// Each word is a reed pulse edge or a poll with a microsecond timestamp. The front end takes one
// word per cycle while the queue has room, applies the debounce lockout and stop timeout, updates
// the count and period at once, and places the word in a two-entry queue. The back end then takes
// each word from the queue, runs a restoring divider that forms the rpm and mm/s quotients side by
// side, forms the mph product, divides that product four bits at a time, and loads the output
// register, waiting while that register still holds a word that has not been taken. It takes no
// new word from the queue until it has loaded the output register for the last one; bursts of up
// to three words are absorbed without stalling the input.
module anemometer_period_speed_meter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  apm_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output apm_pkg::out_word_t             out_word_o,
  input  logic                           cfg_we_i,
  input  logic [apm_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [apm_pkg::DataBits-1:0]   cfg_data_i
);

  logic [apm_pkg::DataBits-1:0] debounce_q, stop_timeout_q, speed_scale_q;
  logic                         push_valid, push_ready, pop_valid, pop_ready;
  apm_pkg::job_t                push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= apm_pkg::DebounceReset;
      stop_timeout_q <= apm_pkg::StopReset;
      speed_scale_q  <= apm_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        apm_pkg::CfgDebounce:    debounce_q     <= cfg_data_i;
        apm_pkg::CfgStopTimeout: stop_timeout_q <= cfg_data_i;
        apm_pkg::CfgSpeedScale:  speed_scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  apm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_word_i      (in_word_i),
    .debounce_i     (debounce_q),
    .stop_timeout_i (stop_timeout_q),
    .job_valid_o    (push_valid),
    .job_ready_i    (push_ready),
    .job_o          (push_job)
  );

  apm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  apm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (pop_valid),
    .job_ready_o   (pop_ready),
    .job_i         (pop_job),
    .speed_scale_i (speed_scale_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_o    (out_word_o)
  );

endmodule

/* src/apm_front.sv */
module apm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  apm_pkg::in_word_t            in_word_i,
  input  logic [apm_pkg::DataBits-1:0] debounce_i,
  input  logic [apm_pkg::DataBits-1:0] stop_timeout_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output apm_pkg::job_t                job_o
);

  logic [apm_pkg::DataBits-1:0] last_q, last_d;
  logic [apm_pkg::DataBits-1:0] period_q, period_d;
  logic [apm_pkg::DataBits-1:0] rev_q, rev_d;
  logic [apm_pkg::DataBits-1:0] elapsed;
  logic                         pulse_ok;
  logic                         accept;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i & job_ready_i;
  assign elapsed     = in_word_i.now_us - last_q;

  always_comb begin
    last_d   = last_q;
    period_d = period_q;
    rev_d    = rev_q;
    pulse_ok = 1'b0;
    case (in_word_i.operation)
      apm_pkg::OpPulse: begin
        if (elapsed >= debounce_i) begin
          pulse_ok = 1'b1;
          if (last_q != '0) begin
            period_d = elapsed;
          end
          last_d = in_word_i.now_us;
          rev_d  = rev_q + 1'b1;
        end
      end
      default: begin
        if ((last_q != '0) && (elapsed > stop_timeout_i)) begin
          period_d = '0;
        end
      end
    endcase
  end

  assign job_o = '{pulse_accepted: pulse_ok, revolutions: rev_d, period_us: period_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      period_q <= '0;
      rev_q    <= '0;
    end else if (accept) begin
      last_q   <= last_d;
      period_q <= period_d;
      rev_q    <= rev_d;
    end
  end

  a_poll_not_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_word_i.operation == apm_pkg::OpPoll) |-> !job_o.pulse_accepted)
    else $error("poll word marked as accepted pulse");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && job_o.pulse_accepted |=> rev_q == $past(rev_q) + 1'b1)
    else $error("revolution count did not advance on accepted pulse");

endmodule

/* src/apm_queue.sv */
module apm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  apm_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output apm_pkg::job_t pop_job_o
);

  apm_pkg::job_t                         mem_q [apm_pkg::QueueDepth];
  logic [apm_pkg::QueuePtrBits-1:0]      wr_ptr_q, rd_ptr_q;
  logic [apm_pkg::QueueCountBits-1:0]    count_q;
  logic                                  push, pop;

  assign push_ready_o = count_q != apm_pkg::QueueCountBits'(apm_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  function automatic logic [apm_pkg::QueuePtrBits-1:0] next_ptr(
    input logic [apm_pkg::QueuePtrBits-1:0] ptr
  );
    if (ptr == apm_pkg::QueuePtrBits'(apm_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= apm_pkg::QueueCountBits'(apm_pkg::QueueDepth))
    else $error("queue fill count out of range");

endmodule

/* src/apm_back.sv */
module apm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  apm_pkg::job_t                job_i,
  input  logic [apm_pkg::DataBits-1:0] speed_scale_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output apm_pkg::out_word_t           out_word_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StMul,
    StMph,
    StLoad
  } state_e;

  state_e                              state_q;
  logic [apm_pkg::CntBits-1:0]         cnt_q;
  apm_pkg::job_t                       job_q;
  logic [apm_pkg::DataBits-1:0]        rem_r_q, rem_s_q, quo_r_q, quo_s_q;
  logic [apm_pkg::DataBits-1:0]        mms_q;
  logic [apm_pkg::MphDenBits-1:0]      rem_m_q;
  logic [apm_pkg::MphQuotBits-1:0]     mph_q;
  logic                                out_valid_q;
  apm_pkg::out_word_t                  out_q;

  logic [apm_pkg::DataBits-1:0]        rem_r_d, rem_s_d, quo_r_d, quo_s_d;
  logic [apm_pkg::DataBits:0]          tr_r, tr_s;
  logic [apm_pkg::DataBits:0]          per_ext;
  logic [apm_pkg::DataBits-1:0]        mms;
  logic [apm_pkg::ProdBits-1:0]        prod;
  logic [apm_pkg::MphDenBits-1:0]      rem_m_d;
  logic [apm_pkg::MphQuotBits-1:0]     mph_d;
  logic                                per_zero;

  assign per_zero = job_q.period_us == '0;
  assign per_ext  = {1'b0, job_q.period_us};

  always_comb begin
    tr_r    = {rem_r_q, quo_r_q[apm_pkg::DataBits-1]};
    tr_s    = {rem_s_q, quo_s_q[apm_pkg::DataBits-1]};
    quo_r_d = {quo_r_q[apm_pkg::DataBits-2:0], 1'b0};
    quo_s_d = {quo_s_q[apm_pkg::DataBits-2:0], 1'b0};
    rem_r_d = tr_r[apm_pkg::DataBits-1:0];
    rem_s_d = tr_s[apm_pkg::DataBits-1:0];
    if (tr_r >= per_ext) begin
      rem_r_d    = apm_pkg::DataBits'(tr_r - per_ext);
      quo_r_d[0] = 1'b1;
    end
    if (tr_s >= per_ext) begin
      rem_s_d    = apm_pkg::DataBits'(tr_s - per_ext);
      quo_s_d[0] = 1'b1;
    end
  end

  assign mms  = per_zero ? '0 : quo_s_q;
  assign prod = apm_pkg::ProdBits'(mms) * apm_pkg::ProdBits'(apm_pkg::MphNum);

  always_comb begin
    logic [apm_pkg::MphDenBits:0] t;
    t       = '0;
    rem_m_d = rem_m_q;
    mph_d   = mph_q;
    for (int i = 0; i < apm_pkg::MphDigitBits; i++) begin
      t     = {rem_m_d, mph_d[apm_pkg::MphQuotBits-1]};
      mph_d = {mph_d[apm_pkg::MphQuotBits-2:0], 1'b0};
      if (t >= {1'b0, apm_pkg::MphDen}) begin
        t        = t - {1'b0, apm_pkg::MphDen};
        mph_d[0] = 1'b1;
      end
      rem_m_d = t[apm_pkg::MphDenBits-1:0];
    end
  end

  assign job_ready_o = state_q == StIdle;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      job_q       <= '0;
      rem_r_q     <= '0;
      rem_s_q     <= '0;
      quo_r_q     <= '0;
      quo_s_q     <= '0;
      mms_q       <= '0;
      rem_m_q     <= '0;
      mph_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != StLoad)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            rem_r_q <= '0;
            rem_s_q <= '0;
            quo_r_q <= apm_pkg::RpmQ4Num;
            quo_s_q <= speed_scale_i;
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          rem_r_q <= rem_r_d;
          rem_s_q <= rem_s_d;
          quo_r_q <= quo_r_d;
          quo_s_q <= quo_s_d;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == apm_pkg::CntBits'(apm_pkg::DivSteps - 1)) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          mms_q   <= mms;
          mph_q   <= apm_pkg::MphQuotBits'(prod);
          rem_m_q <= '0;
          cnt_q   <= '0;
          state_q <= StMph;
        end
        StMph: begin
          rem_m_q <= rem_m_d;
          mph_q   <= mph_d;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == apm_pkg::CntBits'(apm_pkg::MphSteps - 1)) begin
            state_q <= StLoad;
          end
        end
        StLoad: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q            <= 1'b1;
            out_q.pulse_accepted   <= job_q.pulse_accepted;
            out_q.revolutions      <= job_q.revolutions;
            out_q.period_us        <= job_q.period_us;
            out_q.rpm_q4           <= per_zero ? '0 : quo_r_q[apm_pkg::RpmBits-1:0];
            out_q.speed_mm_per_s   <= mms_q;
            out_q.speed_milli_mph  <= (|mph_q[apm_pkg::MphQuotBits-1:apm_pkg::DataBits]) ?
                                      '1 : mph_q[apm_pkg::DataBits-1:0];
            state_q                <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.period_us == '0) |->
      (out_word_o.rpm_q4 == '0) && (out_word_o.speed_mm_per_s == '0) &&
      (out_word_o.speed_milli_mph == '0))
    else $error("nonzero speed reported with zero period");

  a_rpm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.rpm_q4 <= apm_pkg::RpmQ4Num[apm_pkg::RpmBits-1:0])
    else $error("rpm result above its numerator");

endmodule

/* tb/anemometer_period_speed_meter_checker.sv */
module anemometer_period_speed_meter_checker
  import apm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [DataBits-1:0]   cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  logic [DataBits-1:0] lockout_us;
  logic [DataBits-1:0] timeout_us;
  logic [DataBits-1:0] scale;
  logic [DataBits-1:0] last_edge_us;
  logic [DataBits-1:0] period_us;
  logic [DataBits-1:0] rev_count;
  out_word_t           expected_reports[$];
  out_word_t           wanted;
  int unsigned         mismatches;

  function automatic out_word_t next_speed_report(input in_word_t word);
    out_word_t           rep;
    logic [DataBits-1:0] since_edge;
    logic [DataBits-1:0] rpm_full;
    logic [63:0]         mph_full;
    rep = '0;
    since_edge = word.now_us - last_edge_us;
    if (word.operation == OpPulse) begin
      if (since_edge >= lockout_us) begin
        if (last_edge_us != '0) period_us = since_edge;
        last_edge_us = word.now_us;
        rev_count = rev_count + 1'b1;
        rep.pulse_accepted = 1'b1;
      end
    end else if (last_edge_us != '0 && since_edge > timeout_us) begin
      period_us = '0;
    end
    rep.revolutions = rev_count;
    rep.period_us = period_us;
    if (period_us != '0) begin
      rpm_full = RpmQ4Num / period_us;
      rep.rpm_q4 = rpm_full[RpmBits-1:0];
      rep.speed_mm_per_s = scale / period_us;
      mph_full = 64'(rep.speed_mm_per_s) * 64'(MphNum) / 64'(MphDen);
      rep.speed_milli_mph = (mph_full > 64'hFFFF_FFFF) ? '1 : mph_full[DataBits-1:0];
    end
    return rep;
  endfunction

  function automatic void check_field(input string name, input logic [DataBits-1:0] want,
                                      input logic [DataBits-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_us = DebounceReset;
      timeout_us = StopReset;
      scale = ScaleReset;
      last_edge_us = '0;
      period_us = '0;
      rev_count = '0;
      mismatches = 0;
      expected_reports.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDebounce:    lockout_us = cfg_data_i;
          CfgStopTimeout: timeout_us = cfg_data_i;
          CfgSpeedScale:  scale = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_reports.push_back(next_speed_report(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report word with none expected, actual %p", $time, out_word_i);
          mismatches++;
        end else begin
          wanted = expected_reports.pop_front();
          check_field("pulse_accepted", 32'(wanted.pulse_accepted), 32'(out_word_i.pulse_accepted));
          check_field("revolutions", wanted.revolutions, out_word_i.revolutions);
          check_field("period_us", wanted.period_us, out_word_i.period_us);
          check_field("rpm_q4", 32'(wanted.rpm_q4), 32'(out_word_i.rpm_q4));
          check_field("speed_mm_per_s", wanted.speed_mm_per_s, out_word_i.speed_mm_per_s);
          check_field("speed_milli_mph", wanted.speed_milli_mph, out_word_i.speed_milli_mph);
        end
      end
      fail_count_o <= mismatches;
      pending_o <= expected_reports.size();
    end
  end

endmodule

/* tb/anemometer_period_speed_meter_top_test.sv */
module anemometer_period_speed_meter_top_test;
  import apm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = CfgDebounce;
  logic [DataBits-1:0]   cfg_data = '0;
  int unsigned           fails;
  int unsigned           pending;

  logic [DataBits-1:0]   stamp = '0;
  logic [DataBits-1:0]   lockout = DebounceReset;
  logic [DataBits-1:0]   timeout = StopReset;
  logic                  tx_idle = 1'b0;
  logic                  rx_idle = 1'b0;
  logic                  hold_off_req = 1'b0;

  anemometer_period_speed_meter_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  anemometer_period_speed_meter_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // A long hold-off lets the queue fill up so that the input is stalled.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (399) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic op, input logic [DataBits-1:0] now_us);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= '{operation: op, now_us: now_us};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    pause_input(1);
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [DataBits-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_meter(input logic [DataBits-1:0] lo, input logic [DataBits-1:0] to,
                           input logic [DataBits-1:0] sc);
    write_reg(CfgDebounce, lo);
    write_reg(CfgStopTimeout, to);
    write_reg(CfgSpeedScale, sc);
    lockout = lo;
    timeout = to;
  endtask

  // Timestamps mostly advance past the lockout or inside it, sometimes past the stop timeout,
  // and now and then jump anywhere or land on zero.
  task automatic send_random();
    logic [DataBits-1:0] advance;
    logic                op;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    op = ($urandom_range(0, 3) == 0) ? OpPoll : OpPulse;
    if (pick < 45) advance = lockout + ($urandom % (lockout / 2 + 1));
    else if (pick < 65) advance = (lockout == '0) ? '0 : $urandom % lockout;
    else if (pick < 75) advance = timeout + $urandom_range(0, 2);
    else if (pick < 85) advance = timeout + ($urandom % (timeout / 4 + 1));
    else if (pick < 95) advance = $urandom;
    else advance = '0 - stamp;
    stamp = stamp + advance;
    send_word(op, stamp);
    if (tx_idle && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 19));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(OpPulse, 32'd0);
    send_word(OpPulse, 32'd39999);
    send_word(OpPulse, 32'd40000);
    send_word(OpPulse, 32'd50000);
    send_word(OpPulse, 32'd100000);
    send_word(OpPoll, 32'd3100000);
    send_word(OpPoll, 32'd3100001);
    send_word(OpPulse, 32'd4000000);
    send_word(OpPulse, 32'hFFFF_FFFF);
    send_word(OpPulse, 32'd39999);
    send_word(OpPulse, 32'd0);
    send_word(OpPoll, 32'h7FFF_FFFF);
    send_word(OpPulse, 32'd50000);
    settle();
    set_meter('0, '1, '1);
    send_word(OpPulse, 32'd50000);
    send_word(OpPulse, 32'd50001);
    send_word(OpPoll, 32'hF000_0000);
    settle();
    set_meter(32'd1, '0, '0);
    send_word(OpPulse, 32'd50003);
    send_word(OpPoll, 32'd50004);
    send_word(OpPoll, 32'd50003);

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: begin
          set_meter(DebounceReset, StopReset, ScaleReset);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        1: begin
          set_meter($urandom_range(1, 200), $urandom_range(1, 5000), $urandom);
          tx_idle = 1'b0;
          hold_off_req = 1'b1;
        end
        2: set_meter('0, '1, '1);
        3: begin
          set_meter('1, 32'd1, 32'd1);
          tx_idle = 1'b1;
          rx_idle = 1'b0;
        end
        4: begin
          set_meter($urandom, $urandom, $urandom);
          rx_idle = 1'b1;
        end
        5: begin
          set_meter($urandom_range(1000, 100000), $urandom_range(100000, 4000000), '0);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        6: begin
          set_meter(32'd1, '0, $urandom);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        default: begin
          set_meter($urandom_range(10000, 60000), $urandom_range(1000000, 5000000), ScaleReset);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
      endcase
      stamp = $urandom;
      for (int n = 0; n < 250; n++) send_random();
    end

    settle();
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
